### rtl/pmp_pkg.sv
package pmp_pkg;

   localparam int PATTERN_MAX = 32;
   localparam longint TEXT_MAX = 65536;

   localparam int BYTE_W = 8;
   localparam int LEN_W = $clog2(PATTERN_MAX + 1);
   localparam int COUNT_W = $clog2(TEXT_MAX + 1);
   localparam int START_W = 16;

   localparam logic KIND_PATTERN = 1'b0;
   localparam logic KIND_TEXT = 1'b1;

   typedef logic [PATTERN_MAX-1:0][BYTE_W-1:0] byte_vec_type;

   typedef struct packed {
      logic              kind;
      logic [BYTE_W-1:0] data_byte;
      logic              is_last;
   } item_type;

   typedef struct packed {
      logic [LEN_W-1:0] length;
      logic             rejected;
      logic             start_new;
   } pat_status_type;

endpackage

### rtl/pmp_pattern.sv
module pmp_pattern
   import pmp_pkg::*;
(
   input  logic           clock,
   input  logic           reset,
   input  logic           step,
   input  item_type       item,
   output byte_vec_type   pattern,
   output pat_status_type status
);

   byte_vec_type     pat_ff, pat_in;
   logic [LEN_W-1:0] len_ff, len_in;
   logic             loading_ff, loading_in;
   logic             rejected_ff, rejected_in;
   logic [LEN_W-1:0] base_len;

   // The newest pattern byte sits at tap 0, so tap i lines up with window tap i.
   always_comb begin
      pat_in = pat_ff;
      len_in = len_ff;
      loading_in = loading_ff;
      rejected_in = rejected_ff;
      base_len = loading_ff ? len_ff : '0;
      if (step) begin
         unique case (item.kind)
            KIND_PATTERN: begin
               rejected_in = loading_ff ? rejected_ff : 1'b0;
               len_in = base_len;
               if (base_len < LEN_W'(PATTERN_MAX)) begin
                  pat_in = {pat_ff[PATTERN_MAX-2:0], item.data_byte};
                  len_in = base_len + LEN_W'(1);
               end else begin
                  rejected_in = 1'b1;
               end
               loading_in = !item.is_last;
            end
            KIND_TEXT: begin
               loading_in = 1'b0;
            end
            default: begin
               loading_in = loading_ff;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      pat_ff <= pat_in;
      if (reset) begin
         len_ff <= '0;
         loading_ff <= 1'b0;
         rejected_ff <= 1'b0;
      end else begin
         len_ff <= len_in;
         loading_ff <= loading_in;
         rejected_ff <= rejected_in;
      end
   end

   assign pattern = pat_ff;
   assign status.length = len_ff;
   assign status.rejected = rejected_ff;
   assign status.start_new = (item.kind == KIND_PATTERN) && !loading_ff;

endmodule

### rtl/pmp_text.sv
module pmp_text
   import pmp_pkg::*;
(
   input  logic               clock,
   input  logic               reset,
   input  logic               step,
   input  item_type           item,
   input  byte_vec_type       pattern,
   input  pat_status_type     status,
   output logic               match_found,
   output logic [START_W-1:0] match_start
);

   byte_vec_type       win_ff, win_in;
   logic [COUNT_W-1:0] count_ff, count_in;
   logic [COUNT_W-1:0] seen;
   logic [COUNT_W-1:0] start_full;
   logic [PATTERN_MAX-1:0] lane_ok;
   logic               in_range;
   logic               hit;

   assign win_in = {win_ff[PATTERN_MAX-2:0], item.data_byte};
   assign in_range = count_ff < COUNT_W'(TEXT_MAX);
   assign seen = count_ff + COUNT_W'(1);
   assign start_full = seen - COUNT_W'(status.length);

   always_comb begin
      for (int i = 0; i < PATTERN_MAX; i++) begin
         lane_ok[i] = (LEN_W'(i) >= status.length) || (win_in[i] == pattern[i]);
      end
   end

   assign hit = (item.kind == KIND_TEXT) && in_range && !status.rejected
                && (status.length != '0) && (seen >= COUNT_W'(status.length))
                && (&lane_ok);

   always_comb begin
      count_in = count_ff;
      if (step) begin
         unique case (item.kind)
            KIND_PATTERN: begin
               if (status.start_new) begin
                  count_in = '0;
               end
            end
            KIND_TEXT: begin
               if (item.is_last) begin
                  count_in = '0;
               end else if (in_range) begin
                  count_in = seen;
               end
            end
            default: begin
               count_in = count_ff;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (step && item.kind == KIND_TEXT) begin
         win_ff <= win_in;
      end
      if (reset) begin
         count_ff <= '0;
      end else begin
         count_ff <= count_in;
      end
   end

   assign match_found = hit;
   assign match_start = !hit ? '0 :
                        (start_full > COUNT_W'({START_W{1'b1}})) ? {START_W{1'b1}} :
                        START_W'(start_full);

endmodule

### rtl/pattern_match_positions.sv
// Exact pattern search over a byte stream.
// The request channel (req_valid, req_stall, req_kind, req_data_byte, req_is_last)
// carries pattern bytes (kind 0, last byte marked) and text bytes (kind 1).
// Every request transfer gives exactly one response transfer on the rsp_ channel:
// rsp_match_found is set when the newest pattern-length window of text equals the
// pattern, and rsp_match_start gives the offset of that window in the current text.
// Pattern bytes always answer with no match.
// An item passes an input register and then a result register, and one item is
// taken every cycle unless req_stall holds the request channel.
// The rate is set by the parallel compare of all window taps against the pattern,
// which fits between those two registers.
// While rsp_stall holds a waiting response, the input register still takes one
// more item; req_stall rises only when both registers are full.
// Synchronous reset empties both registers, forgets the pattern and the text
// offset; the block accepts items in the cycle after reset falls.
module pattern_match_positions
   import pmp_pkg::*;
(
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_stall,
   input  logic               req_kind,
   input  logic [BYTE_W-1:0]  req_data_byte,
   input  logic               req_is_last,
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output logic               rsp_match_found,
   output logic [START_W-1:0] rsp_match_start
);

   item_type           s1_item_ff;
   logic               s1_valid_ff, s1_valid_in;
   logic               rsp_valid_ff, rsp_valid_in;
   logic               rsp_found_ff;
   logic [START_W-1:0] rsp_start_ff;
   logic               out_free;
   logic               step;
   logic               req_take;
   byte_vec_type       pattern;
   pat_status_type     status;
   logic               found;
   logic [START_W-1:0] start;

   assign out_free = !rsp_valid_ff || !rsp_stall;
   assign step = s1_valid_ff && out_free;
   assign req_stall = s1_valid_ff && !out_free;
   assign req_take = req_valid && !req_stall;

   assign s1_valid_in = req_take || (s1_valid_ff && !step);
   assign rsp_valid_in = step || (rsp_valid_ff && rsp_stall);

   always_ff @(posedge clock) begin
      if (req_take) begin
         s1_item_ff <= '{kind: req_kind, data_byte: req_data_byte, is_last: req_is_last};
      end
      if (step) begin
         rsp_found_ff <= found;
         rsp_start_ff <= start;
      end
      if (reset) begin
         s1_valid_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= s1_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   pmp_pattern u_pattern (
      .clock   (clock),
      .reset   (reset),
      .step    (step),
      .item    (s1_item_ff),
      .pattern (pattern),
      .status  (status)
   );

   pmp_text u_text (
      .clock       (clock),
      .reset       (reset),
      .step        (step),
      .item        (s1_item_ff),
      .pattern     (pattern),
      .status      (status),
      .match_found (found),
      .match_start (start)
   );

   assign rsp_valid = rsp_valid_ff;
   assign rsp_match_found = rsp_found_ff;
   assign rsp_match_start = rsp_start_ff;

   a_start_zero_without_match: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && !rsp_found_ff |-> rsp_start_ff == '0)
      else $error("match offset set without a match");

   a_stall_only_when_full: assert property (@(posedge clock) disable iff (reset)
      req_stall |-> s1_valid_ff && rsp_valid_ff && rsp_stall)
      else $error("request stalled with room in the pipeline");

   a_pattern_never_matches: assert property (@(posedge clock) disable iff (reset)
      step && s1_item_ff.kind == KIND_PATTERN |=> rsp_valid_ff && !rsp_found_ff)
      else $error("pattern byte reported a match");

   a_step_fills_result: assert property (@(posedge clock) disable iff (reset)
      step |=> rsp_valid_ff)
      else $error("advanced item did not reach the result register");

endmodule

### tb/tb_pattern_match_positions.sv
module tb_pattern_match_positions
   import pmp_pkg::*;
();
   timeunit 1ns;
   timeprecision 1ps;

   typedef struct packed {
      logic               found;
      logic [START_W-1:0] start;
   } match_result_type;

   typedef logic [BYTE_W-1:0] byte_list_type [$];

   logic               clock;
   logic               reset = 1'b1;
   logic               req_valid = 1'b0;
   logic               req_stall;
   logic               req_kind = KIND_PATTERN;
   logic [BYTE_W-1:0]  req_data_byte = '0;
   logic               req_is_last = 1'b0;
   logic               rsp_valid;
   logic               rsp_stall = 1'b0;
   logic               rsp_match_found;
   logic [START_W-1:0] rsp_match_start;

   pattern_match_positions uut (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_stall       (req_stall),
      .req_kind        (req_kind),
      .req_data_byte   (req_data_byte),
      .req_is_last     (req_is_last),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_match_found (rsp_match_found),
      .rsp_match_start (rsp_match_start)
   );

   logic [BYTE_W-1:0] pat_bytes [PATTERN_MAX] = '{default: '0};
   logic [BYTE_W-1:0] text_tail [PATTERN_MAX] = '{default: '0};
   int unsigned       pat_len = 0;
   bit                pat_open = 1'b0;
   bit                pat_rejected = 1'b0;
   longint            text_seen = 0;

   match_result_type  expected_matches [$];

   int send_idle_pct = 0;
   int rsp_idle_pct = 0;
   int stall_hold_cycles = 0;
   int items_sent = 0;
   int hits_seen = 0;
   int input_held_cycles = 0;
   int mismatch_count = 0;

   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   initial begin
      #1_000_000;
      $display("[FAIL] regression broken");
      $finish;
   end

   function automatic void clear_text_tail();
      int i;
      for (i = 0; i < PATTERN_MAX; i++) text_tail[i] = '0;
      text_seen = 0;
   endfunction

   function automatic match_result_type predict_match(input logic kind,
                                                      input logic [BYTE_W-1:0] data,
                                                      input logic last);
      match_result_type res;
      bit               equal;
      int               i;
      longint           offset;
      res.found = 1'b0;
      res.start = '0;
      if (kind == KIND_PATTERN) begin
         if (!pat_open) begin
            pat_len = 0;
            pat_rejected = 1'b0;
            clear_text_tail();
         end
         if (pat_len < PATTERN_MAX) begin
            pat_bytes[pat_len] = data;
            pat_len++;
         end else begin
            pat_rejected = 1'b1;
         end
         pat_open = !last;
      end else begin
         pat_open = 1'b0;
         for (i = PATTERN_MAX - 1; i > 0; i--) text_tail[i] = text_tail[i - 1];
         text_tail[0] = data;
         if (text_seen < TEXT_MAX) begin
            text_seen++;
            if (!pat_rejected && pat_len > 0 && text_seen >= pat_len) begin
               equal = 1'b1;
               for (i = 0; i < pat_len; i++) begin
                  if (text_tail[i] != pat_bytes[pat_len - 1 - i]) equal = 1'b0;
               end
               if (equal) begin
                  offset = text_seen - pat_len;
                  res.found = 1'b1;
                  res.start = (offset > 65535) ? '1 : START_W'(offset);
               end
            end
         end
         if (last) clear_text_tail();
      end
      return res;
   endfunction

   function automatic void report_mismatch(input string msg);
      mismatch_count++;
      if (mismatch_count <= 10) $display("mismatch at %0t: %s", $realtime, msg);
   endfunction

   always @(posedge clock) begin
      if (reset) begin
         rsp_stall <= 1'b0;
      end else if (stall_hold_cycles > 0) begin
         rsp_stall <= 1'b1;
         stall_hold_cycles <= stall_hold_cycles - 1;
      end else begin
         rsp_stall <= ($urandom_range(99) < rsp_idle_pct);
      end
   end

   always @(posedge clock) begin : check_results
      match_result_type want;
      if (!reset) begin
         if (req_valid && req_stall) input_held_cycles++;
         if (rsp_valid && !rsp_stall) begin
            if (expected_matches.size() == 0) begin
               report_mismatch($sformatf("unexpected response found=%0b start=%0d",
                                         rsp_match_found, rsp_match_start));
            end else begin
               want = expected_matches.pop_front();
               if (want.found) hits_seen++;
               if (rsp_match_found !== want.found)
                  report_mismatch($sformatf("match_found expected %0b, got %0b",
                                            want.found, rsp_match_found));
               if (rsp_match_start !== want.start)
                  report_mismatch($sformatf("match_start expected %0d, got %0d",
                                            want.start, rsp_match_start));
            end
         end
      end
   end

   task automatic send_item(input logic kind, input logic [BYTE_W-1:0] data,
                            input logic last);
      if (send_idle_pct > 0 && $urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         do @(posedge clock); while ($urandom_range(99) < send_idle_pct);
      end
      req_valid <= 1'b1;
      req_kind <= kind;
      req_data_byte <= data;
      req_is_last <= last;
      do @(posedge clock); while (req_stall);
      expected_matches.insert(expected_matches.size(), predict_match(kind, data, last));
      items_sent++;
   endtask

   task automatic send_pattern(input byte_list_type bytes, input bit close);
      foreach (bytes[i]) send_item(KIND_PATTERN, bytes[i], close && (i == bytes.size() - 1));
   endtask

   task automatic send_text(input byte_list_type bytes, input bit close);
      foreach (bytes[i]) send_item(KIND_TEXT, bytes[i], close && (i == bytes.size() - 1));
   endtask

   // Pattern and text share a narrow byte range so that hits are frequent.
   task automatic send_random_search(input int plen);
      byte_list_type     pat;
      byte_list_type     txt;
      logic [BYTE_W-1:0] base;
      int                spread;
      int                tlen;
      base = BYTE_W'($urandom_range(255));
      spread = int'($urandom_range(2));
      repeat (plen) pat.insert(pat.size(), BYTE_W'(base + $urandom_range(spread)));
      send_pattern(pat, $urandom_range(9) != 0);
      repeat ($urandom_range(1, 3)) begin
         txt.delete();
         tlen = $urandom_range(1, (plen > 12) ? 40 : 3 * plen + 6);
         while (txt.size() < tlen) begin
            if ($urandom_range(99) < 30) begin
               foreach (pat[i]) txt.insert(txt.size(), pat[i]);
            end else begin
               txt.insert(txt.size(), BYTE_W'(base + $urandom_range(spread)));
            end
         end
         send_text(txt, $urandom_range(7) != 0);
      end
   endtask

   task automatic test_no_pattern();
      send_item(KIND_TEXT, 8'h00, 1'b0);
      send_item(KIND_TEXT, 8'hFF, 1'b1);
   endtask

   task automatic test_single_byte();
      send_item(KIND_PATTERN, 8'hA5, 1'b1);
      send_item(KIND_TEXT, 8'hA5, 1'b0);
      send_item(KIND_TEXT, 8'hA5, 1'b0);
      send_item(KIND_TEXT, 8'h3C, 1'b1);
   endtask

   task automatic test_unfinished_load();
      send_item(KIND_PATTERN, 8'h00, 1'b0);
      send_item(KIND_PATTERN, 8'hFF, 1'b0);
      send_item(KIND_TEXT, 8'h00, 1'b0);
      send_item(KIND_TEXT, 8'hFF, 1'b0);
      send_item(KIND_TEXT, 8'h00, 1'b0);
      send_item(KIND_TEXT, 8'hFF, 1'b1);
   endtask

   task automatic test_short_text();
      send_item(KIND_PATTERN, 8'h11, 1'b0);
      send_item(KIND_PATTERN, 8'h22, 1'b0);
      send_item(KIND_PATTERN, 8'h33, 1'b1);
      send_item(KIND_TEXT, 8'h11, 1'b0);
      send_item(KIND_TEXT, 8'h22, 1'b1);
      send_item(KIND_TEXT, 8'h11, 1'b0);
      send_item(KIND_TEXT, 8'h22, 1'b0);
      send_item(KIND_TEXT, 8'h33, 1'b1);
   endtask

   task automatic test_text_boundary();
      send_item(KIND_PATTERN, 8'h61, 1'b0);
      send_item(KIND_PATTERN, 8'h62, 1'b1);
      send_item(KIND_TEXT, 8'h61, 1'b1);
      send_item(KIND_TEXT, 8'h62, 1'b1);
      send_item(KIND_TEXT, 8'h78, 1'b0);
      send_item(KIND_TEXT, 8'h61, 1'b0);
      send_item(KIND_TEXT, 8'h62, 1'b1);
   endtask

   task automatic test_full_pattern();
      byte_list_type pat;
      byte_list_type txt;
      repeat (PATTERN_MAX) pat.insert(pat.size(), BYTE_W'($urandom_range(255)));
      send_pattern(pat, 1'b1);
      repeat (3) txt.insert(txt.size(), BYTE_W'($urandom_range(255)));
      foreach (pat[i]) txt.insert(txt.size(), pat[i]);
      foreach (pat[i]) txt.insert(txt.size(), pat[i]);
      send_text(txt, 1'b1);
      pat.delete();
      txt.delete();
      repeat (PATTERN_MAX) pat.insert(pat.size(), 8'h77);
      repeat (PATTERN_MAX + 2) txt.insert(txt.size(), 8'h77);
      send_pattern(pat, 1'b1);
      send_text(txt, 1'b1);
   endtask

   task automatic test_overlong_pattern();
      byte_list_type pat;
      repeat (PATTERN_MAX) pat.insert(pat.size(), BYTE_W'($urandom_range(255)));
      send_pattern(pat, 1'b0);
      send_item(KIND_PATTERN, 8'hFF, 1'b1);
      send_text(pat, 1'b1);
      send_pattern(pat, 1'b1);
      send_text(pat, 1'b1);
   endtask

   task automatic test_random_traffic(input int goal);
      int first;
      int pick;
      first = items_sent;
      while (items_sent - first < goal) begin
         pick = $urandom_range(99);
         if (pick < 8) begin
            repeat ($urandom_range(4, 16))
               send_item(1'($urandom_range(1)), BYTE_W'($urandom_range(255)),
                         1'($urandom_range(1)));
         end else if (pick < 13) begin
            send_random_search($urandom_range(PATTERN_MAX + 1, PATTERN_MAX + 3));
         end else if (pick < 25) begin
            send_random_search($urandom_range(5, PATTERN_MAX));
         end else begin
            send_random_search($urandom_range(1, 4));
         end
      end
   endtask

   // The receiver blocks for a long stretch, so the block fills and stalls its input.
   task automatic test_fill_and_stall();
      stall_hold_cycles <= 150;
      repeat (3) send_random_search($urandom_range(1, 4));
   endtask

   // Alternating bytes give a hit at the even offsets of a long text; rare random bytes break some pairs.
   task automatic test_long_text();
      int                k;
      logic [BYTE_W-1:0] data;
      send_item(KIND_PATTERN, 8'h5A, 1'b0);
      send_item(KIND_PATTERN, 8'hA5, 1'b1);
      for (k = 0; k < 256; k++) begin
         data = (k % 2 == 0) ? 8'h5A : 8'hA5;
         if ($urandom_range(49) == 0) data = BYTE_W'($urandom_range(255));
         send_item(KIND_TEXT, data, k == 255);
      end
      send_item(KIND_TEXT, 8'h5A, 1'b0);
      send_item(KIND_TEXT, 8'hA5, 1'b1);
   endtask

   initial begin
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      send_idle_pct = 31;
      rsp_idle_pct = 77;
      test_no_pattern();
      test_single_byte();
      test_unfinished_load();
      test_short_text();
      test_text_boundary();
      test_full_pattern();
      test_overlong_pattern();
      test_random_traffic(400);

      send_idle_pct = 77;
      rsp_idle_pct = 31;
      test_random_traffic(400);

      send_idle_pct = 0;
      rsp_idle_pct = 0;
      test_random_traffic(400);
      test_fill_and_stall();
      test_long_text();

      req_valid <= 1'b0;
      while (expected_matches.size() != 0) @(posedge clock);
      repeat (10) @(posedge clock);

      $display("Covered %0d transfers with %0d hits, patterns of 1 to %0d bytes,",
               items_sent, hits_seen, PATTERN_MAX + 3);
      $display("unfinished and overlong loads, and %0d cycles of held-off input.",
               input_held_cycles);
      if (mismatch_count == 0 && expected_matches.size() == 0) begin
         $display("[ OK ] regression clean");
      end else begin
         $display("%0d mismatches, %0d responses missing", mismatch_count,
                  expected_matches.size());
         $display("[FAIL] regression broken");
      end
      $finish;
   end

endmodule
